[hw/rtl/orrl_pkg.sv]
package orrl_pkg;

	localparam int ADDR_W = 24;
	localparam int CODE_W = 48;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int OUT_W  = ADDR_W + CODE_W + ADDR_W;

	// result kinds carried on tuser
	localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WORD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E; // '^'
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54; // 'T'
	localparam logic [CHAR_W-1:0] CH_E     = 8'h45; // 'E'

	localparam logic [ADDR_W-1:0] WORD_STEP = 24'd3;

	typedef struct packed {
		logic              ok;
		logic [3:0]        val;
	} hex_digit_t;

	// space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_ws(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic hex_digit_t hex_digit(input logic [CHAR_W-1:0] c);
		hex_digit_t d;
		d.ok  = 1'b1;
		d.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			d.val = c[3:0] + 4'd9;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage

[hw/rtl/object_record_relocating_loader_top.sv]
// Relocating loader for a caret-separated object program.
//
// Input channel (s_*): one ASCII character per request on s_tdata. Whitespace
// ends a record. The first record is the header (start address, length);
// T records carry object code, an E record ends the program.
// Output channel (m_*): one request per result. m_tuser holds the kind
// (header, relocated word, end); m_tdata holds address, six code characters
// and program length.
// Configuration: cfg_wr_en / cfg_wr_data write load_address, which is
// sampled when the header record closes. Write it while the block is idle.
//
// Timing: a taken character sits in the input register until its parse
// step, which updates the parser state and, when a result is due, loads
// the result register that drives m_*.
// One character per cycle sustained while results are taken: each parse
// is a single short step. When the receiver stalls, the result register
// holds and an empty input register still takes one character; after that
// s_tready drops until the result is taken.
// Reset clears the parser to wait for a header and empties both registers.
// After an E record every character is accepted and dropped until reset.
module object_record_relocating_loader_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [orrl_pkg::CHAR_W-1:0]       s_tdata,  // [7:0] char_in
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [orrl_pkg::OUT_W-1:0]        m_tdata,  // [23:0] address,
	                                                    // [71:24] code_chars,
	                                                    // [95:72] program_length
	output logic [orrl_pkg::KIND_W-1:0]       m_tuser,  // [1:0] kind
	input  logic                              cfg_wr_en,
	input  logic [orrl_pkg::ADDR_W-1:0]       cfg_wr_data
);
	import orrl_pkg::*;

	typedef enum logic [2:0] {
		M_WAIT_HDR,
		M_HEADER,
		M_BETWEEN,
		M_T_ADDR,
		M_T_SKIP,
		M_T_DATA,
		M_OTHER,
		M_STOPPED
	} mode_t;

	// configuration
	logic [ADDR_W-1:0] load_addr_q;

	// input register
	logic              vld_s1;
	logic [CHAR_W-1:0] char_s1;

	// parser state
	mode_t             mode_q,   mode_d;
	logic [1:0]        pos_q,    pos_d;
	logic [ADDR_W-1:0] hex_q,    hex_d;
	logic              hstop_q,  hstop_d;
	logic [ADDR_W-1:0] start_q,  start_d;
	logic [ADDR_W-1:0] offset_q, offset_d;
	logic [ADDR_W-1:0] cur_q,    cur_d;
	logic [CODE_W-1:0] grp_q,    grp_d;
	logic [2:0]        gcnt_q,   gcnt_d;
	logic [1:0]        caret_q,  caret_d;
	logic [ADDR_W-1:0] len_q,    len_d;

	// result register
	logic              out_vld_q;
	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CODE_W-1:0] code_q;
	logic [ADDR_W-1:0] plen_q;

	// emission from the current parse step
	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [ADDR_W-1:0] e_addr;
	logic [CODE_W-1:0] e_code;
	logic [ADDR_W-1:0] e_len;

	logic              adv;
	logic              fire;
	logic              ws;
	hex_digit_t        hd;
	logic [ADDR_W-1:0] hex_fed;
	logic              hstop_fed;

	// the parse step runs whenever the result register is free or draining
	assign adv      = !out_vld_q || m_tready;
	assign fire     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	assign ws = is_ws(char_s1);
	assign hd = hex_digit(char_s1);

	// hex accumulation, stopping at the first non-hex character
	always_comb begin
		hex_fed   = hex_q;
		hstop_fed = hstop_q;
		if (!hstop_q) begin
			if (hd.ok) begin
				hex_fed = {hex_q[ADDR_W-5:0], hd.val};
			end else begin
				hstop_fed = 1'b1;
			end
		end
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		hex_d    = hex_q;
		hstop_d  = hstop_q;
		start_d  = start_q;
		offset_d = offset_q;
		cur_d    = cur_q;
		grp_d    = grp_q;
		gcnt_d   = gcnt_q;
		caret_d  = caret_q;
		len_d    = len_q;
		emit     = 1'b0;
		e_kind   = KIND_HDR;
		e_addr   = '0;
		e_code   = '0;
		e_len    = '0;

		unique case (mode_q)
			M_WAIT_HDR: begin
				if (!ws) begin
					mode_d  = M_HEADER;
					pos_d   = 2'd1;
					caret_d = 2'd0;
					gcnt_d  = 3'd0;
					grp_d   = '0;
					hex_d   = '0;
					hstop_d = 1'b0;
				end
			end
			M_HEADER: begin
				if (ws) begin
					// close the header: latch the open field, fix the offset
					if (caret_q == 2'd1) begin
						start_d = hex_q;
					end else if (caret_q == 2'd2) begin
						len_d = hex_q;
					end
					offset_d = load_addr_q - start_d;
					mode_d   = M_BETWEEN;
					emit     = 1'b1;
					e_kind   = KIND_HDR;
					e_addr   = start_d;
					e_len    = len_d;
				end else if (pos_q < 2'd2) begin
					pos_d = pos_q + 2'd1;
				end else if (char_s1 == CH_CARET) begin
					if (caret_q == 2'd1) begin
						start_d = hex_q;
					end else if (caret_q == 2'd2) begin
						len_d = hex_q;
					end
					if (caret_q < 2'd3) begin
						caret_d = caret_q + 2'd1;
					end
					hex_d   = '0;
					hstop_d = 1'b0;
				end else if (caret_q == 2'd1 || caret_q == 2'd2) begin
					hex_d   = hex_fed;
					hstop_d = hstop_fed;
				end
			end
			M_BETWEEN: begin
				if (!ws) begin
					if (char_s1 == CH_T) begin
						mode_d  = M_T_ADDR;
						pos_d   = 2'd1;
						caret_d = 2'd0;
						gcnt_d  = 3'd0;
						grp_d   = '0;
						hex_d   = '0;
						hstop_d = 1'b0;
					end else if (char_s1 == CH_E) begin
						mode_d = M_STOPPED;
						emit   = 1'b1;
						e_kind = KIND_END;
					end else begin
						mode_d = M_OTHER;
					end
				end
			end
			M_T_ADDR: begin
				if (ws) begin
					mode_d = M_BETWEEN;
				end else if (pos_q < 2'd2) begin
					pos_d = pos_q + 2'd1;
				end else if (char_s1 == CH_CARET) begin
					cur_d   = hex_q + offset_q;
					caret_d = 2'd1;
					mode_d  = M_T_SKIP;
				end else begin
					hex_d   = hex_fed;
					hstop_d = hstop_fed;
				end
			end
			M_T_SKIP: begin
				if (ws) begin
					mode_d = M_BETWEEN;
				end else if (char_s1 == CH_CARET) begin
					caret_d = 2'd2;
					gcnt_d  = 3'd0;
					grp_d   = '0;
					mode_d  = M_T_DATA;
				end
			end
			M_T_DATA: begin
				if (ws) begin
					mode_d = M_BETWEEN;
				end else if (!(gcnt_q == 3'd0 && char_s1 == CH_CARET)) begin
					if (gcnt_q == 3'd5) begin
						// sixth character completes the group
						emit   = 1'b1;
						e_kind = KIND_WORD;
						e_addr = cur_q;
						e_code = {grp_q[CODE_W-CHAR_W-1:0], char_s1};
						gcnt_d = 3'd0;
						grp_d  = '0;
						cur_d  = cur_q + WORD_STEP;
					end else begin
						grp_d  = {grp_q[CODE_W-CHAR_W-1:0], char_s1};
						gcnt_d = gcnt_q + 3'd1;
					end
				end
			end
			M_OTHER: begin
				if (ws) begin
					mode_d = M_BETWEEN;
				end
			end
			default: begin
				// stopped: drop everything until reset
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_addr_q <= '0;
		end else if (cfg_wr_en) begin
			load_addr_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	// parser state: advance on each parsed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_WAIT_HDR;
			pos_q    <= '0;
			hex_q    <= '0;
			hstop_q  <= 1'b0;
			start_q  <= '0;
			offset_q <= '0;
			cur_q    <= '0;
			grp_q    <= '0;
			gcnt_q   <= '0;
			caret_q  <= '0;
			len_q    <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			hex_q    <= hex_d;
			hstop_q  <= hstop_d;
			start_q  <= start_d;
			offset_q <= offset_d;
			cur_q    <= cur_d;
			grp_q    <= grp_d;
			gcnt_q   <= gcnt_d;
			caret_q  <= caret_d;
			len_q    <= len_d;
		end
	end

	// result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q <= e_kind;
			addr_q <= e_addr;
			code_q <= e_code;
			plen_q <= e_len;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {plen_q, code_q, addr_q};

endmodule

[hw/rtl/orrl_checker.sv]
module orrl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [orrl_pkg::CHAR_W-1:0]       s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [orrl_pkg::OUT_W-1:0]        m_tdata,
	input logic [orrl_pkg::KIND_W-1:0]       m_tuser,
	input logic                              cfg_wr_en,
	input logic [orrl_pkg::ADDR_W-1:0]       cfg_wr_data
);
	import orrl_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_HDR || m_tuser == KIND_WORD || m_tuser == KIND_END))
		else $error("illegal result kind");

	a_hdr_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_HDR |-> m_tdata[ADDR_W+CODE_W-1:ADDR_W] == '0)
		else $error("header carries code characters");

	a_len_hdr_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_HDR |-> m_tdata[OUT_W-1:ADDR_W+CODE_W] == '0)
		else $error("program length outside header");

	// an end result carries nothing but its kind
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tdata == '0)
		else $error("end result carries data");

endmodule

bind object_record_relocating_loader_top orrl_checker u_orrl_checker (.*);
